// File: rtl/euc_jp_to_shift_jis_defines.svh
// Assertion macros shared by the euc_jp_to_shift_jis RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef EUC_JP_TO_SHIFT_JIS_DEFINES_SVH
`define EUC_JP_TO_SHIFT_JIS_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EJSJ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EJSJ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ejsj_pkg.sv
// Shared constants, the result record type and conversion helpers.
// No dependencies; used by ejsj_core, ejsj_out_fifo and the top level.
package ejsj_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] SS2       = 8'h8E;
    localparam logic [7:0] SS3       = 8'h8F;
    localparam logic [7:0] KANJI_MIN = 8'hA0;
    localparam logic [6:0] ROW_MASK  = 7'h7F;
    localparam logic [7:0] ROW_SPLIT = 8'h5F;
    localparam logic [7:0] LO_BASE   = 8'h70;
    localparam logic [7:0] HI_BASE   = 8'hB0;
    localparam logic [7:0] CELL_HI   = 8'h20;
    localparam logic [7:0] CELL_LO   = 8'h1F;
    localparam logic [7:0] CELL_EVEN = 8'h7E;

    // Bytes produced by one input item: n is 1..3, bytes go out b0 first.
    typedef struct packed {
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } ejsj_rec_t;

    function automatic logic opens_seq(input logic [7:0] b);
        opens_seq = (b == SS2) || (b == SS3) || (b >= KANJI_MIN);
    endfunction

    // JIS X 0208 pair (EUC form) to Shift-JIS; result is {first, second}.
    function automatic logic [15:0] jis_to_sjis(input logic [7:0] lead, input logic [7:0] trail);
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] half;
        logic [7:0] first;
        logic [7:0] second;
        row    = {1'b0, lead[6:0] & ROW_MASK};
        col    = {1'b0, trail[6:0] & ROW_MASK};
        half   = (row + 8'd1) >> 1;
        first  = (row < ROW_SPLIT) ? half + LO_BASE : half + HI_BASE;
        if (lead[0])
            second = (col > ROW_SPLIT) ? col + CELL_HI : col + CELL_LO;
        else
            second = col + CELL_EVEN;
        jis_to_sjis = {first, second};
    endfunction

endpackage

// File: rtl/ejsj_core.sv
// Sequence tracker and converter: held bytes plus combinational decode of each item.
// Depends on ejsj_pkg and euc_jp_to_shift_jis_defines.svh.
`include "euc_jp_to_shift_jis_defines.svh"

module ejsj_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    output logic              push,
    output ejsj_pkg::ejsj_rec_t rec
);

    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [7:0] held0_reg;
    logic [7:0] held0_next;
    logic [7:0] held1_reg;
    logic [7:0] held1_next;
    logic [15:0] sjis;

    assign sjis = ejsj_pkg::jis_to_sjis(held0_reg, in_byte);

    always_comb
    begin
        held_count_next = 2'd0;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        rec.n           = 2'd0;
        rec.b0          = in_byte;
        rec.b1          = in_byte;
        rec.b2          = in_byte;
        case (held_count_reg)
            2'd0:
            begin
                if (ejsj_pkg::opens_seq(in_byte))
                begin
                    held0_next      = in_byte;
                    held_count_next = 2'd1;
                end
                else
                begin
                    rec.n = 2'd1;
                end
            end
            2'd1:
            begin
                if (held0_reg == ejsj_pkg::SS2)
                begin
                    rec.n = 2'd1;
                end
                else if (held0_reg == ejsj_pkg::SS3)
                begin
                    held1_next      = in_byte;
                    held_count_next = 2'd2;
                end
                else if (in_byte >= ejsj_pkg::KANJI_MIN)
                begin
                    rec.n  = 2'd2;
                    rec.b0 = sjis[15:8];
                    rec.b1 = sjis[7:0];
                end
                else
                begin
                    // lone lead byte goes out; this byte starts over if it opens a sequence, else goes out too
                    rec.b0 = held0_reg;
                    if (ejsj_pkg::opens_seq(in_byte))
                    begin
                        rec.n           = 2'd1;
                        held0_next      = in_byte;
                        held_count_next = 2'd1;
                    end
                    else
                    begin
                        rec.n = 2'd2;
                    end
                end
            end
            default:
            begin
                // SS3 plus middle byte held
                rec.b0 = ejsj_pkg::SS3;
                if ((held1_reg >= ejsj_pkg::KANJI_MIN) && (in_byte >= ejsj_pkg::KANJI_MIN))
                begin
                    rec.n  = 2'd3;
                    rec.b1 = held1_reg;
                end
                else if (held1_reg == ejsj_pkg::SS2)
                begin
                    rec.n = 2'd2;
                end
                else if (held1_reg == ejsj_pkg::SS3)
                begin
                    rec.n           = 2'd1;
                    held0_next      = ejsj_pkg::SS3;
                    held1_next      = in_byte;
                    held_count_next = 2'd2;
                end
                else
                begin
                    // middle byte is plain text or a lead with no valid trail
                    rec.b1 = held1_reg;
                    if (ejsj_pkg::opens_seq(in_byte))
                    begin
                        rec.n           = 2'd2;
                        held0_next      = in_byte;
                        held_count_next = 2'd1;
                    end
                    else
                    begin
                        rec.n = 2'd3;
                    end
                end
            end
        endcase
    end

    assign push = accept && (rec.n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_count_reg <= 2'd0;
        else if (accept)
            held_count_reg <= held_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    `EJSJ_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, held_count_reg != 2'd3,
        "held count out of range")
    `EJSJ_ASSERT_IMP(a_ss3_lead, clk, rst_n, held_count_reg == 2'd2,
        held0_reg == ejsj_pkg::SS3, "two bytes held without SS3 lead")
    `EJSJ_ASSERT_IMP(a_hold_or_emit, clk, rst_n, accept && (held_count_next == 2'd0),
        (rec.n != 2'd0) || ((held_count_reg == 2'd1) && (held0_reg == ejsj_pkg::SS3)) || 1'b0,
        "item cleared state without output")

endmodule

// File: rtl/ejsj_out_fifo.sv
// Result queue: one record of up to three bytes per item, drained a byte per cycle while out_stall is low.
// Depends on ejsj_pkg and euc_jp_to_shift_jis_defines.svh.
`include "euc_jp_to_shift_jis_defines.svh"

module ejsj_out_fifo
#(
    parameter int DEPTH = ejsj_pkg::FIFO_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ejsj_pkg::ejsj_rec_t rec,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                last_of_run
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ejsj_pkg::ejsj_rec_t entries [DEPTH];
    ejsj_pkg::ejsj_rec_t head;

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       idx_reg;
    logic             take;
    logic             pop;

    assign head        = entries[rd_ptr_reg];
    assign full        = (count_reg == CNT_FULL);
    assign out_valid   = (count_reg != '0);
    assign last_of_run = (idx_reg == (head.n - 2'd1));
    assign take        = out_valid && !out_stall;
    assign pop         = take && last_of_run;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    out_byte = head.b0;
            2'd1:    out_byte = head.b1;
            default: out_byte = head.b2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
                idx_reg    <= 2'd0;
            end
            else if (take)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= rec;
    end

    `EJSJ_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full, "push into full result queue")
    `EJSJ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL,
        "result queue count out of range")
    `EJSJ_ASSERT_NXT(a_idx_step, clk, rst_n, take && !last_of_run,
        idx_reg == $past(idx_reg) + 2'd1, "byte index did not advance")

endmodule

// File: rtl/euc_jp_to_shift_jis.sv
// Top level of the EUC-JP to Shift-JIS byte stream converter.
// Depends on ejsj_pkg, ejsj_core and ejsj_out_fifo.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------
//  in      | sink      | in_valid/in_stall   | in_byte, buffer_end
//  out     | source    | out_valid/out_stall | out_byte, last_of_run
//
// An input item is decoded in the cycle it is accepted and its record is queued;
// its bytes leave the queue in order, one byte per cycle while out_stall is low.
// Up to three bytes per item; input stalls only while the FIFO_DEPTH-record
// result queue is full, and each way moves at most one byte per cycle.
// Reset clears the held-sequence count and the result queue.
// buffer_end carries no function: partial sequences stay held across buffers.
module euc_jp_to_shift_jis
#(
    parameter int FIFO_DEPTH = ejsj_pkg::FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       buffer_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic                accept;
    logic                push;
    logic                full;
    ejsj_pkg::ejsj_rec_t rec;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    ejsj_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .push    (push),
        .rec     (rec)
    );

    ejsj_out_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .rec         (rec),
        .full        (full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
